// ===== rtl/xsort_pkg.sv =====
// Shared types and constants for the exchange sort block.
// No dependencies; every other file imports this package.
package xsort_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int DATA_W    = 32;

    // One input beat.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_in;
    } in_beat_t;

    // One result beat.
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } out_beat_t;

    // Contents of one cell, or an element travelling between cells.
    typedef struct packed {
        logic                     vld;
        logic signed [DATA_W-1:0] data;
    } slot_t;

endpackage

// ===== rtl/xsort_cell.sv =====
// One cell of the sorting chain: keeps the smaller element, passes the larger right.
// Depends on xsort_pkg.
module xsort_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  xsort_pkg::slot_t carry_in,
    input  xsort_pkg::slot_t right_slot,
    output xsort_pkg::slot_t slot,
    output xsort_pkg::slot_t carry_out
);
    import xsort_pkg::*;

    slot_t slot_reg, slot_next;
    slot_t carry_reg, carry_next;

    always_comb
    begin
        slot_next  = slot_reg;
        carry_next = carry_reg;
        carry_next.vld = 1'b0;
        if (shift)
        begin
            slot_next = right_slot;
        end
        else if (carry_in.vld)
        begin
            if (!slot_reg.vld)
            begin
                slot_next = carry_in;
            end
            else if (carry_in.data < slot_reg.data)
            begin
                // newcomer is smaller: keep it, push the old one on
                slot_next  = carry_in;
                carry_next = slot_reg;
            end
            else
            begin
                // ties go right so arrival order holds
                carry_next = carry_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            carry_reg <= '0;
        end
        else
        begin
            slot_reg  <= slot_next;
            carry_reg <= carry_next;
        end
    end

    assign slot      = slot_reg;
    assign carry_out = carry_reg;

endmodule

// ===== rtl/exchange_sort_integer_top.sv =====
// Exchange sorter top: a chain of DEPTH insertion cells plus a small control FSM.
// After the last input beat the chain settles, then n result beats come out back to back
// (n = elements stored, 1..DEPTH). Each element is loaded, left to settle, then emitted; the
// insertion wave moves one cell per cycle. A new set is taken only once the last one is out.
// busy is high from the last input beat until the final result; results cannot be stalled.
// Reset (rst_n, async, active low) empties all cells and clears count and overflow.
module exchange_sort_integer_top #(
    parameter int DEPTH = xsort_pkg::DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  xsort_pkg::in_beat_t  item,
    output logic                 busy,
    output logic                 strobe,
    output xsort_pkg::out_beat_t result
);
    import xsort_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // One-hot control states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,  // collecting input beats
        ST_SETTLE = 3'b010,  // letting the last insertions ripple down the chain
        ST_DRAIN  = 3'b100   // shifting sorted elements out of cell 0
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;      // elements held in the chain
    logic [CW-1:0]   timer_reg, timer_next;  // settle countdown
    logic            ovf_reg, ovf_next;      // an element of this set was dropped

    logic            accept;
    logic            full;
    logic            shift;
    slot_t           inject;
    slot_t           cell_slot  [DEPTH];
    slot_t           cell_carry [DEPTH];

    assign accept = start && (state_reg == ST_IDLE);
    assign full   = (cnt_reg == CW'(DEPTH));
    assign shift  = (state_reg == ST_DRAIN);

    // New element enters cell 0 unless the chain is already full.
    always_comb
    begin
        inject.vld  = accept && !full;
        inject.data = item.value;
    end

    // ------------------------------------------------------------------
    // Cell chain. Each insertion wave moves one cell per cycle; in drain
    // every cell loads its right neighbor, and an empty slot enters at the end.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        slot_t carry_in_i;
        slot_t right_i;

        if (i == 0)
        begin : g_head
            assign carry_in_i = inject;
        end
        else
        begin : g_body
            assign carry_in_i = cell_carry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_i = '0;
        end
        else
        begin : g_mid
            assign right_i = cell_slot[i+1];
        end

        xsort_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (shift),
            .carry_in   (carry_in_i),
            .right_slot (right_i),
            .slot       (cell_slot[i]),
            .carry_out  (cell_carry[i])
        );
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        timer_next = timer_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (item.last_in)
                    begin
                        // settle countdown starts from the number of elements now stored
                        timer_next = full ? cnt_reg : cnt_reg + CW'(1);
                        state_next = ST_SETTLE;
                    end
                end
            end
            ST_SETTLE:
            begin
                timer_next = timer_reg - CW'(1);
                if (timer_reg <= CW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            timer_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            timer_reg <= timer_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Result beat comes straight from cell 0 and registered control.
    assign busy   = (state_reg != ST_IDLE);
    assign strobe = shift;
    always_comb
    begin
        result.sorted_value = cell_slot[0].data;
        result.last_out     = shift && (cnt_reg == CW'(1));
        result.overflow     = ovf_reg;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("element count above store depth");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last_out) |=> !busy)
        else $error("block still busy after final result beat");

    a_last_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last_in) |=> (busy && !strobe))
        else $error("final input beat did not start the settle phase");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> cell_slot[0].vld)
        else $error("result beat taken from an empty cell");

    a_drain_settled: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !cell_carry[0].vld)
        else $error("insertion still in flight while draining");

    a_tail_no_spill: assert property (@(posedge clk) disable iff (!rst_n)
        !cell_carry[DEPTH-1].vld)
        else $error("element pushed out of the last cell");

endmodule

// ===== bench/xsort_checker.sv =====
// Scoreboard for the exchange sort block. It follows input and result beats,
// predicts every sorted set and compares the results field by field.
// Depends on xsort_pkg.
module xsort_checker #(
    parameter int DEPTH = xsort_pkg::DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  xsort_pkg::in_beat_t  item,
    input  logic                 strobe,
    input  xsort_pkg::out_beat_t result,
    output int                   fail_cnt,
    output int                   pending
);
    import xsort_pkg::*;

    typedef logic signed [DATA_W-1:0] elem_t;

    elem_t     held_q[$];     // elements of the set being collected
    logic      dropped;       // an element of this set hit a full store
    out_beat_t sorted_q[$];   // sorted results still owed by the block
    int        errs;

    // Stable ascending order: each element lands after every one not greater.
    function automatic void predict_sorted_set();
        elem_t     ordered[$];
        out_beat_t beat;
        int        pos;
        foreach (held_q[i])
        begin
            pos = ordered.size();
            while (pos > 0 && ordered[pos-1] > held_q[i])
                pos--;
            ordered.insert(pos, held_q[i]);
        end
        foreach (ordered[i])
        begin
            beat.sorted_value = ordered[i];
            beat.last_out     = (i == ordered.size() - 1);
            beat.overflow     = dropped;
            sorted_q.push_back(beat);
        end
    endfunction

    function automatic void check_sorted_beat(out_beat_t got);
        out_beat_t want;
        if (sorted_q.size() == 0)
        begin
            $error("result beat with nothing expected: sorted_value %0d", got.sorted_value);
            errs++;
            return;
        end
        want = sorted_q.pop_front();
        if (got.sorted_value !== want.sorted_value)
        begin
            $error("sorted_value: expected %0d, got %0d", want.sorted_value, got.sorted_value);
            errs++;
        end
        if (got.last_out !== want.last_out)
        begin
            $error("last_out: expected %0b, got %0b", want.last_out, got.last_out);
            errs++;
        end
        if (got.overflow !== want.overflow)
        begin
            $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
            errs++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_q.delete();
            sorted_q.delete();
            dropped  = 1'b0;
            errs     = 0;
            fail_cnt <= 0;
            pending  <= 0;
        end
        else
        begin
            // results first: a beat leaving now belongs to an older set
            if (strobe === 1'b1)
                check_sorted_beat(result);
            else if (strobe !== 1'b0)
            begin
                $error("strobe: expected 0 or 1, got %b", strobe);
                errs++;
            end

            if (start === 1'b1 && busy === 1'b0)
            begin
                if (held_q.size() < DEPTH)
                    held_q.push_back(item.value);
                else
                    dropped = 1'b1;
                if (item.last_in)
                begin
                    predict_sorted_set();
                    held_q.delete();
                    dropped = 1'b0;
                end
            end

            fail_cnt <= errs;
            pending  <= sorted_q.size();
        end
    end

endmodule

// ===== bench/tb_exchange_sort_integer_top.sv =====
// Top of the exchange sort bench: clock, reset, beat stimulus and verdict.
// Depends on xsort_pkg, exchange_sort_integer_top and xsort_checker.
module tb_exchange_sort_integer_top;

    import xsort_pkg::*;

    localparam int DEPTH     = DEPTH_DEF;
    localparam int NUM_ITEMS = 130;
    // after the last beat: room for the settle phase and the result beats, plus margin
    localparam int DRAIN_CYC = 3 * DEPTH + 20;

    typedef logic signed [DATA_W-1:0] elem_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    in_beat_t  item;
    logic      busy;
    logic      strobe;
    out_beat_t result;

    int        fail_cnt;
    int        pending;

    int        items_sent;
    int        idle_pct;      // chance, in percent, that the sender idles a cycle
    elem_t     set_q[$];      // elements of the next set to send

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    exchange_sort_integer_top #(
        .DEPTH (DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    xsort_checker #(
        .DEPTH (DEPTH)
    ) checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .strobe   (strobe),
        .result   (result),
        .fail_cnt (fail_cnt),
        .pending  (pending)
    );

    // Hard stop in case the block hangs or never finishes a set.
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // One input beat. Random idle cycles go in front of it; start stays high
    // across back-to-back beats so it never gets two updates in one step.
    // Returns right after the edge that took the beat.
    task automatic send_beat(input elem_t v, input logic lst);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        item.value   <= v;
        item.last_in <= lst;
        // busy is sampled as it was before the edge, i.e. as the block saw it
        do
            @(posedge clk);
        while (busy !== 1'b0);
        items_sent++;
    endtask

    // Sends set_q as one set, with the last flag on its final element.
    task automatic send_set();
        foreach (set_q[i])
            send_beat(set_q[i], i == set_q.size() - 1);
        set_q.delete();
    endtask

    // Sender holds off until the block has delivered every expected beat.
    // pending is registered, so the first edge lets it catch up.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mix of full-range values, a narrow band that yields many equal values,
    // and the corners of the signed range.
    function automatic elem_t rand_elem();
        elem_t v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 6) - 3;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = '0;
                    default: v = -1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Mostly short sets; now and then one around the store depth, which
    // may spill over and exercise the full-store path.
    task automatic send_random_set();
        int n;
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(DEPTH - 1, DEPTH + 4);
        else
            n = $urandom_range(1, 8);
        repeat (n)
            set_q.push_back(rand_elem());
        send_set();
    endtask

    initial
    begin
        int phase_pct[3];

        // every input known from time zero
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        items_sent = 0;
        idle_pct   = 0;
        phase_pct  = '{0, 49, 23};

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------
        // one-element set
        set_q = '{32'sd0};
        send_set();
        // signed extremes, the value next to the minimum and values around zero, scrambled
        set_q = '{32'sh7FFF_FFFF, 32'sh8000_0000, -1, 0, 1, 32'sh8000_0001};
        send_set();
        // equal values mixed with others
        set_q = '{5, 5, -3, 5};
        send_set();
        // already ascending, then strictly descending
        set_q = '{-2, -1, 0, 7};
        send_set();
        set_q = '{100, 50, 0, -50, -100};
        send_set();
        // pause until the directed sets are all back
        wait_drained();

        // store full: two extra elements, the final one among the dropped
        for (int i = 0; i < DEPTH + 2; i++)
            set_q.push_back(rand_elem());
        send_set();

        // ---------------- random part, three idling phases ----------------
        foreach (phase_pct[p])
        begin
            idle_pct = phase_pct[p];
            while (items_sent < NUM_ITEMS * (p + 1) / 3)
                send_random_set();
            // sender pause with the block empty before the next phase
            wait_drained();
        end

        // all beats taken; wait for the results, then let stray beats show
        wait_drained();
        repeat (DRAIN_CYC)
            @(posedge clk);

        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/xsort_pkg.sv
rtl/xsort_cell.sv
rtl/exchange_sort_integer_top.sv
bench/xsort_checker.sv
bench/tb_exchange_sort_integer_top.sv
